// ===== rtl/lfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lfc_pkg;

	localparam int HEADER_BYTES = 8;
	localparam int CRC_BYTES    = 2;
	localparam int FRAME_MIN    = HEADER_BYTES + CRC_BYTES;

	localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'h1021;
	localparam logic [15:0] CRC_MSB   = 16'h8000;

	localparam int ADDR_W = 5;

	localparam logic [2:0] REG_MAGIC   = 3'd0;
	localparam logic [2:0] REG_VERSION = 3'd1;
	localparam logic [2:0] REG_TYPE_A  = 3'd2;
	localparam logic [2:0] REG_TYPE_B  = 3'd3;
	localparam logic [2:0] REG_TYPE_C  = 3'd4;
	localparam logic [2:0] REG_MAX_LEN = 3'd5;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_BAD_MAGIC = 3'd2,
		ST_BAD_LEN   = 3'd3,
		ST_BAD_CRC   = 3'd4,
		ST_BAD_TYPE  = 3'd5
	} status_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_STATUS  = 1'b1
	} kind_t;

	typedef struct packed {
		logic [15:0] magic_word;
		logic [7:0]  version_code;
		logic [7:0]  type_code_a;
		logic [7:0]  type_code_b;
		logic [7:0]  type_code_c;
		logic [15:0] max_payload;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		magic_word:   16'd0,
		version_code: 8'd0,
		type_code_a:  8'd1,
		type_code_b:  8'd2,
		type_code_c:  8'd3,
		max_payload:  16'd64
	};

	// one queue entry: what a single input byte causes
	typedef struct packed {
		logic        has_pay;
		logic [7:0]  pay;
		logic        has_stat;
		logic [7:0]  mtype;
		logic [15:0] seq;
		logic [15:0] len;
		status_t     status;
	} entry_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_MSB) != 16'd0) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/lfc_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lfc_regs (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       psel,
	input  wire                       penable,
	input  wire                       pwrite,
	input  wire [lfc_pkg::ADDR_W-1:0] paddr,
	input  wire [31:0]                pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output lfc_pkg::cfg_t             cfg
);
	import lfc_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign idx    = paddr[4:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_MAGIC:   cfg_q.magic_word   <= pwdata[15:0];
				REG_VERSION: cfg_q.version_code <= pwdata[7:0];
				REG_TYPE_A:  cfg_q.type_code_a  <= pwdata[7:0];
				REG_TYPE_B:  cfg_q.type_code_b  <= pwdata[7:0];
				REG_TYPE_C:  cfg_q.type_code_c  <= pwdata[7:0];
				REG_MAX_LEN: cfg_q.max_payload  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MAGIC:   prdata = {16'd0, cfg_q.magic_word};
			REG_VERSION: prdata = {24'd0, cfg_q.version_code};
			REG_TYPE_A:  prdata = {24'd0, cfg_q.type_code_a};
			REG_TYPE_B:  prdata = {24'd0, cfg_q.type_code_b};
			REG_TYPE_C:  prdata = {24'd0, cfg_q.type_code_c};
			REG_MAX_LEN: prdata = {16'd0, cfg_q.max_payload};
			default:     prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/lfc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lfc_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire [7:0]           data_byte,
	input  wire                 frame_end,
	input  lfc_pkg::cfg_t       cfg,
	input  wire                 q_ready,
	output logic                q_push,
	output lfc_pkg::entry_t     q_entry
);
	import lfc_pkg::*;

	logic [16:0] count_q;
	logic [15:0] crc_q;
	logic [7:0]  dly0_q;
	logic [7:0]  dly1_q;
	logic [15:0] hdr_magic_q;
	logic [7:0]  hdr_ver_q;
	logic [7:0]  hdr_type_q;
	logic [15:0] hdr_seq_q;
	logic [15:0] hdr_len_q;

	logic [15:0] hdr_magic_n;
	logic [7:0]  hdr_ver_n;
	logic [7:0]  hdr_type_n;
	logic [15:0] hdr_seq_n;
	logic [15:0] hdr_len_n;
	logic [15:0] crc_n;
	logic [17:0] total;
	logic [17:0] want_total;
	logic        past_magic;
	logic        has_pay;
	logic        accept;
	status_t     status;

	assign in_ready = q_ready;
	assign accept   = in_valid & q_ready;

	always_comb begin
		hdr_magic_n = hdr_magic_q;
		hdr_ver_n   = hdr_ver_q;
		hdr_type_n  = hdr_type_q;
		hdr_seq_n   = hdr_seq_q;
		hdr_len_n   = hdr_len_q;
		unique case (count_q)
			17'd0:   hdr_magic_n[7:0]  = data_byte;
			17'd1:   hdr_magic_n[15:8] = data_byte;
			17'd2:   hdr_ver_n         = data_byte;
			17'd3:   hdr_type_n        = data_byte;
			17'd4:   hdr_seq_n[7:0]    = data_byte;
			17'd5:   hdr_seq_n[15:8]   = data_byte;
			17'd6:   hdr_len_n[7:0]    = data_byte;
			17'd7:   hdr_len_n[15:8]   = data_byte;
			default: ;
		endcase
	end

	// byte leaving the delay line enters the crc, and is payload from count 10 on, i.e. from frame byte 8
	assign past_magic = count_q >= 17'd2;
	assign has_pay    = count_q >= 17'(FRAME_MIN);
	assign crc_n      = past_magic ? crc_byte(crc_q, dly1_q) : crc_q;

	assign total      = {1'b0, count_q} + 18'd1;
	assign want_total = 18'(FRAME_MIN) + {2'b00, hdr_len_n};

	always_comb begin
		priority if (total < 18'(FRAME_MIN)) begin
			status = ST_SHORT;
		end else if (hdr_magic_n != cfg.magic_word || hdr_ver_n != cfg.version_code) begin
			status = ST_BAD_MAGIC;
		end else if (hdr_len_n > cfg.max_payload || total != want_total) begin
			status = ST_BAD_LEN;
		end else if (crc_n != {data_byte, dly0_q}) begin
			status = ST_BAD_CRC;
		end else if (hdr_type_n != cfg.type_code_a && hdr_type_n != cfg.type_code_b &&
				hdr_type_n != cfg.type_code_c) begin
			status = ST_BAD_TYPE;
		end else begin
			status = ST_OK;
		end
	end

	assign q_push           = accept & (has_pay | frame_end);
	assign q_entry.has_pay  = has_pay;
	assign q_entry.pay      = dly1_q;
	assign q_entry.has_stat = frame_end;
	assign q_entry.mtype    = hdr_type_n;
	assign q_entry.seq      = hdr_seq_n;
	assign q_entry.len      = hdr_len_n;
	assign q_entry.status   = status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= 17'd0;
			crc_q       <= CRC_INIT;
			dly0_q      <= 8'd0;
			dly1_q      <= 8'd0;
			hdr_magic_q <= 16'd0;
			hdr_ver_q   <= 8'd0;
			hdr_type_q  <= 8'd0;
			hdr_seq_q   <= 16'd0;
			hdr_len_q   <= 16'd0;
		end else if (accept) begin
			if (frame_end) begin
				count_q     <= 17'd0;
				crc_q       <= CRC_INIT;
				dly0_q      <= 8'd0;
				dly1_q      <= 8'd0;
				hdr_magic_q <= 16'd0;
				hdr_ver_q   <= 8'd0;
				hdr_type_q  <= 8'd0;
				hdr_seq_q   <= 16'd0;
				hdr_len_q   <= 16'd0;
			end else begin
				if (count_q != COUNT_MAX) begin
					count_q <= count_q + 17'd1;
				end
				crc_q       <= crc_n;
				dly0_q      <= data_byte;
				dly1_q      <= dly0_q;
				hdr_magic_q <= hdr_magic_n;
				hdr_ver_q   <= hdr_ver_n;
				hdr_type_q  <= hdr_type_n;
				hdr_seq_q   <= hdr_seq_n;
				hdr_len_q   <= hdr_len_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lfc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lfc_queue #(
	parameter int DEPTH = 4
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  lfc_pkg::entry_t     push_entry,
	output logic                push_ready,
	input  wire                 pop,
	output logic                head_valid,
	output lfc_pkg::entry_t     head_entry
);
	import lfc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != CNT_W'(DEPTH)))
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue pop while empty");

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("queue count did not follow push");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers apart while empty");
`endif

endmodule

`default_nettype wire

// ===== rtl/lfc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lfc_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 head_valid,
	input  lfc_pkg::entry_t     head_entry,
	output logic                pop,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic                item_kind,
	output logic [7:0]          payload_byte,
	output logic [7:0]          message_type,
	output logic [15:0]         sequence_res,
	output logic [15:0]         payload_length,
	output logic [2:0]          status_code,
	output logic                last_item
);
	import lfc_pkg::*;

	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  pay_q;
	logic [7:0]  mtype_q;
	logic [15:0] seq_q;
	logic [15:0] len_q;
	logic [2:0]  status_q;
	logic        last_q;
	logic        pay_done_q;

	logic        load;
	logic        send_pay;

	assign load     = head_valid & (!out_valid_q | out_ready);
	// payload half goes first; the entry stays at the head until its status half is out
	assign send_pay = head_entry.has_pay & !pay_done_q;
	assign pop      = load & !(send_pay & head_entry.has_stat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pay_done_q  <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				pay_done_q  <= send_pay & head_entry.has_stat;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (send_pay) begin
				kind_q   <= KIND_PAYLOAD;
				pay_q    <= head_entry.pay;
				mtype_q  <= 8'd0;
				seq_q    <= 16'd0;
				len_q    <= 16'd0;
				status_q <= ST_OK;
				last_q   <= 1'b0;
			end else begin
				kind_q   <= KIND_STATUS;
				pay_q    <= 8'd0;
				mtype_q  <= head_entry.mtype;
				seq_q    <= head_entry.seq;
				len_q    <= head_entry.len;
				status_q <= head_entry.status;
				last_q   <= 1'b1;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign item_kind      = kind_q;
	assign payload_byte   = pay_q;
	assign message_type   = mtype_q;
	assign sequence_res   = seq_q;
	assign payload_length = len_q;
	assign status_code    = status_q;
	assign last_item      = last_q;

`ifndef ASSERT_OFF
	a_split_holds_head: assert property (@(posedge clk) disable iff (!arst_n)
		pay_done_q |-> head_valid)
		else $error("status half pending without queue head");

	a_split_after_payload: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pay_done_q) |-> (out_valid_q && kind_q == KIND_PAYLOAD))
		else $error("split entry without payload item out");

	a_status_after_split: assert property (@(posedge clk) disable iff (!arst_n)
		(pay_done_q && load) |=> (kind_q == KIND_STATUS && !pay_done_q))
		else $error("split entry did not finish with status item");
`endif

endmodule

`default_nettype wire

// ===== rtl/link_frame_checker_core.sv =====
// link frame checker: one frame byte per input item (data_byte, frame_end on
// the final byte). frame layout: magic, version, type, sequence, length (all
// little endian), payload, crc-16/ccitt-false over everything before it.
// payload bytes come out as kind 0 items; the final byte of a frame yields
// one kind 1 status item with the header fields and the check result, after
// any payload byte the same input item pushed out.
// input channel: in_valid/in_ready; output channel: out_valid/out_ready.
// registers sit on an apb port at byte address 4*i, always ready, no waits.
// throughput: one input item per cycle while the queue has room; the final
// byte of a frame may make two result items, which leave one after the other.
// the front updates crc and header for each byte; the back emits one item
// per cycle from its output register while out_ready is high.
// a result item passes from the queue into the output register, which is
// loaded when it is empty or being taken; a status item behind a payload
// item from the same input item follows it once the payload item is taken.
// a queue of QUEUE_DEPTH entries sits between front and back; when the
// receiver stalls, the queue fills and in_ready drops once it is full.
// reset clears frame state, the queue pointers and count, and the output valid
// flag, and loads the register reset values; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module link_frame_checker_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire [7:0]                 data_byte,
	input  wire                       frame_end,
	output logic                      out_valid,
	input  wire                       out_ready,
	output logic                      item_kind,
	output logic [7:0]                payload_byte,
	output logic [7:0]                message_type,
	output logic [15:0]               sequence_res,
	output logic [15:0]               payload_length,
	output logic [2:0]                status_code,
	output logic                      last_item,
	input  wire                       psel,
	input  wire                       penable,
	input  wire                       pwrite,
	input  wire [lfc_pkg::ADDR_W-1:0] paddr,
	input  wire [31:0]                pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	import lfc_pkg::*;

	cfg_t   cfg;
	logic   q_push;
	logic   q_ready;
	entry_t q_entry;
	logic   head_valid;
	entry_t head_entry;
	logic   pop;

	lfc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lfc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.frame_end (frame_end),
		.cfg       (cfg),
		.q_ready   (q_ready),
		.q_push    (q_push),
		.q_entry   (q_entry)
	);

	lfc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.push_ready (q_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	lfc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head_entry     (head_entry),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.item_kind      (item_kind),
		.payload_byte   (payload_byte),
		.message_type   (message_type),
		.sequence_res   (sequence_res),
		.payload_length (payload_length),
		.status_code    (status_code),
		.last_item      (last_item)
	);

endmodule

`default_nettype wire
